>>> src/hrt_pkg.sv
`default_nettype none

package hrt_pkg;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_SP    = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_COLON = 8'd58;

  localparam logic [1:0] PH_REQ    = 2'd0;
  localparam logic [1:0] PH_HDR    = 2'd1;
  localparam logic [1:0] PH_BODY   = 2'd2;
  localparam logic [1:0] PH_IGNORE = 2'd3;

  localparam logic [1:0] HP_NAME  = 2'd0;
  localparam logic [1:0] HP_SEP   = 2'd1;
  localparam logic [1:0] HP_VALUE = 2'd2;

  localparam logic [3:0] CLS_METHOD    = 4'd0;
  localparam logic [3:0] CLS_SPACE     = 4'd1;
  localparam logic [3:0] CLS_PATH      = 4'd2;
  localparam logic [3:0] CLS_VERSION   = 4'd3;
  localparam logic [3:0] CLS_HDR_NAME  = 4'd4;
  localparam logic [3:0] CLS_HDR_SEP   = 4'd5;
  localparam logic [3:0] CLS_HDR_VALUE = 4'd6;
  localparam logic [3:0] CLS_TERM      = 4'd7;
  localparam logic [3:0] CLS_BODY      = 4'd8;
  localparam logic [3:0] CLS_IGNORED   = 4'd9;

  localparam logic [3:0] METHOD_UNKNOWN = 4'd8;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_LINE   = 2'd1;
  localparam logic [1:0] ST_NO_SP_MTH = 2'd2;
  localparam logic [1:0] ST_NO_SP_PTH = 2'd3;

  localparam int NUM_METHODS = 8;
  localparam int METHOD_MAX  = 7;

  // method names, first character in the low byte
  localparam logic [55:0] METHOD_TEXT [NUM_METHODS] = '{
    56'h00000000544547,  // GET
    56'h00000054534F50,  // POST
    56'h00000000545550,  // PUT
    56'h00000044414548,  // HEAD
    56'h00004543415254,  // TRACE
    56'h004554454C4544,  // DELETE
    56'h534E4F4954504F,  // OPTIONS
    56'h5443454E4E4F43   // CONNECT
  };
  localparam logic [3:0] METHOD_LEN [NUM_METHODS] = '{
    4'd3, 4'd4, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd7
  };
  localparam logic [3:0] METHOD_CODE [NUM_METHODS] = '{
    4'd1, 4'd3, 4'd4, 4'd2, 4'd6, 4'd5, 4'd0, 4'd7
  };

  typedef struct packed {
    logic [1:0]  phase;
    logic [1:0]  space_count;
    logic [55:0] method_bytes;
    logic [3:0]  method_length;
    logic        cr_pending;
    logic [1:0]  header_part;
    logic        colon_seen;
    logic        line_nonempty;
    logic        any_line_seen;
    logic [3:0]  method_result;
    logic [1:0]  status_reg;
  } hrt_state_t;

  localparam hrt_state_t HRT_STATE_RST = '{
    phase: PH_REQ, space_count: 2'd0, method_bytes: 56'd0, method_length: 4'd0,
    cr_pending: 1'b0, header_part: HP_NAME, colon_seen: 1'b0,
    line_nonempty: 1'b0, any_line_seen: 1'b0, method_result: METHOD_UNKNOWN,
    status_reg: ST_OK
  };

  typedef struct packed {
    logic [7:0] out_byte;
    logic [3:0] byte_class;
    logic       line_done;
    logic       header_has_colon;
    logic       headers_done;
    logic [3:0] method_code;
    logic [1:0] parse_status;
    logic       request_end;
    logic       last;
  } hrt_result_t;

  typedef struct packed {
    hrt_state_t st;
    logic [3:0] cls;
  } hrt_cls_ret_t;

  typedef struct packed {
    hrt_state_t st;
    logic       ld;
    logic       hc;
    logic       hd;
  } hrt_close_ret_t;

  typedef struct packed {
    hrt_state_t  st_nxt;
    logic        push0;
    logic        push1;
    hrt_result_t res0;
    hrt_result_t res1;
  } hrt_step_t;

  function automatic logic [3:0] match_method(input logic [55:0] text, input logic [3:0] len);
    logic [3:0] code;
    code = METHOD_UNKNOWN;
    if (len <= 4'(METHOD_MAX)) begin
      for (int i = NUM_METHODS - 1; i >= 0; i--) begin
        if (len == METHOD_LEN[i] && text == METHOD_TEXT[i]) code = METHOD_CODE[i];
      end
    end
    return code;
  endfunction

  function automatic hrt_cls_ret_t classify(input hrt_state_t s, input logic [7:0] b);
    hrt_cls_ret_t r;
    r.st  = s;
    r.cls = CLS_IGNORED;
    if (s.phase == PH_BODY) begin
      r.cls = CLS_BODY;
    end else if (s.phase == PH_IGNORE) begin
      r.cls = CLS_IGNORED;
    end else begin
      r.st.line_nonempty = 1'b1;
      if (s.phase == PH_REQ) begin
        if (s.space_count == 2'd0) begin
          if (b == CH_SP) begin
            r.st.space_count = 2'd1;
            r.cls = CLS_SPACE;
          end else begin
            if (s.method_length < 4'(METHOD_MAX))
              r.st.method_bytes[{s.method_length[2:0], 3'b000} +: 8] = b;
            if (s.method_length < 4'd8) r.st.method_length = 4'(s.method_length + 4'd1);
            r.cls = CLS_METHOD;
          end
        end else if (s.space_count == 2'd1) begin
          if (b == CH_SP) begin
            r.st.space_count = 2'd2;
            r.cls = CLS_SPACE;
          end else begin
            r.cls = CLS_PATH;
          end
        end else begin
          r.cls = CLS_VERSION;
        end
      end else begin
        case (s.header_part)
          HP_NAME: begin
            if (b == CH_COLON) begin
              r.st.header_part = HP_SEP;
              r.st.colon_seen  = 1'b1;
              r.cls = CLS_HDR_SEP;
            end else begin
              r.cls = CLS_HDR_NAME;
            end
          end
          HP_SEP: begin
            if (b == CH_SP || b == CH_TAB) begin
              r.cls = CLS_HDR_SEP;
            end else begin
              r.st.header_part = HP_VALUE;
              r.cls = CLS_HDR_VALUE;
            end
          end
          default: begin
            r.cls = CLS_HDR_VALUE;
          end
        endcase
      end
    end
    return r;
  endfunction

  function automatic hrt_close_ret_t close_line(input hrt_state_t s);
    hrt_close_ret_t r;
    r.st = s;
    r.ld = 1'b0;
    r.hc = 1'b0;
    r.hd = 1'b0;
    if (s.phase == PH_REQ) begin
      if (s.line_nonempty) begin
        r.ld = 1'b1;
        r.st.any_line_seen = 1'b1;
        if (s.space_count == 2'd0) begin
          r.st.status_reg    = ST_NO_SP_MTH;
          r.st.method_result = METHOD_UNKNOWN;
        end else if (s.space_count == 2'd1) begin
          r.st.status_reg    = ST_NO_SP_PTH;
          r.st.method_result = METHOD_UNKNOWN;
        end else begin
          r.st.status_reg    = ST_OK;
          r.st.method_result = match_method(s.method_bytes, s.method_length);
        end
        r.st.phase       = PH_HDR;
        r.st.header_part = HP_NAME;
        r.st.colon_seen  = 1'b0;
      end else begin
        r.st.status_reg = ST_NO_LINE;
        r.st.phase      = PH_IGNORE;
      end
    end else begin
      if (s.line_nonempty) begin
        r.ld = 1'b1;
        r.hc = s.colon_seen;
      end else begin
        r.hd = 1'b1;
        r.st.phase = PH_BODY;
      end
      r.st.header_part = HP_NAME;
      r.st.colon_seen  = 1'b0;
    end
    r.st.line_nonempty = 1'b0;
    return r;
  endfunction

  function automatic hrt_result_t make_res(input logic [7:0] b, input logic [3:0] cls,
                                           input logic ld, input logic hc, input logic hd,
                                           input hrt_state_t s);
    hrt_result_t r;
    r.out_byte         = b;
    r.byte_class       = cls;
    r.line_done        = ld;
    r.header_has_colon = hc;
    r.headers_done     = hd;
    r.method_code      = s.method_result;
    r.parse_status     = s.status_reg;
    r.request_end      = 1'b0;
    r.last             = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/hrt_step.sv
`default_nettype none

module hrt_step (
  input  hrt_pkg::hrt_state_t st,
  input  logic [7:0]          in_byte,
  input  logic                eoc,
  output hrt_pkg::hrt_step_t  step
);
  import hrt_pkg::*;

  hrt_state_t     s;
  hrt_cls_ret_t   c0;
  hrt_cls_ret_t   c1;
  hrt_close_ret_t cl;
  logic [1:0]     fin;

  always_comb begin
    s  = st;
    c0 = classify(st, in_byte);
    c1 = c0;
    cl = close_line(st);
    step.push0 = 1'b0;
    step.push1 = 1'b0;
    step.res0  = make_res(in_byte, c0.cls, 1'b0, 1'b0, 1'b0, st);
    step.res1  = step.res0;

    if (st.phase >= PH_BODY) begin
      s = c0.st;
      step.push0 = 1'b1;
    end else if (st.cr_pending) begin
      s.cr_pending = 1'b0;
      if (in_byte == CH_LF) begin
        cl = close_line(s);
        step.res0  = make_res(CH_CR, CLS_TERM, 1'b0, 1'b0, 1'b0, s);
        s          = cl.st;
        step.res1  = make_res(CH_LF, CLS_TERM, cl.ld, cl.hc, cl.hd, s);
        step.push0 = 1'b1;
        step.push1 = 1'b1;
      end else begin
        c0 = classify(s, CH_CR);
        step.res0  = make_res(CH_CR, c0.cls, 1'b0, 1'b0, 1'b0, s);
        step.push0 = 1'b1;
        s          = c0.st;
        if (in_byte == CH_CR && !eoc) begin
          s.cr_pending = 1'b1;
        end else begin
          c1 = classify(s, in_byte);
          s  = c1.st;
          step.res1  = make_res(in_byte, c1.cls, 1'b0, 1'b0, 1'b0, s);
          step.push1 = 1'b1;
        end
      end
    end else if (in_byte == CH_CR && !eoc) begin
      s.cr_pending = 1'b1;
    end else begin
      s = c0.st;
      step.push0 = 1'b1;
    end

    fin = s.any_line_seen ? s.status_reg : ST_NO_LINE;
    if (eoc) begin
      step.res0.method_code  = s.method_result;
      step.res0.parse_status = fin;
      step.res0.request_end  = 1'b1;
      step.res1.method_code  = s.method_result;
      step.res1.parse_status = fin;
      step.res1.request_end  = 1'b1;
    end
    step.res0.last = !step.push1;
    step.res1.last = 1'b1;
    step.st_nxt = eoc ? HRT_STATE_RST : s;
  end

endmodule

`default_nettype wire

>>> src/hrt_rq.sv
`default_nettype none

module hrt_rq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push0,
  input  logic                 push1,
  input  hrt_pkg::hrt_result_t din0,
  input  hrt_pkg::hrt_result_t din1,
  output logic                 room,
  output logic                 dout_valid,
  input  logic                 pop,
  output hrt_pkg::hrt_result_t dout
);
  import hrt_pkg::*;

  localparam int DEPTH = 4;

  hrt_result_t mem_r [DEPTH];
  logic [1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [2:0]  count_r, count_nxt;
  logic        do_pop;
  logic [1:0]  n_push;

  assign do_pop     = pop && (count_r != 3'd0);
  assign n_push     = {1'b0, push0} + {1'b0, push1};
  assign wr_ptr_nxt = 2'(wr_ptr_r + n_push);
  assign rd_ptr_nxt = 2'(rd_ptr_r + {1'b0, do_pop});
  assign count_nxt  = 3'(count_r + {1'b0, n_push} - {2'b00, do_pop});
  assign room       = (count_r <= 3'd2);
  assign dout_valid = (count_r != 3'd0);
  assign dout       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push0) mem_r[wr_ptr_r] <= din0;
    if (push1) mem_r[2'(wr_ptr_r + 2'd1)] <= din1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 3'(DEPTH)) else $error("result queue overflow");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push0 |-> room) else $error("push without room");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != 3'(DEPTH)) |-> (2'(wr_ptr_r - rd_ptr_r) == count_r[1:0]))
    else $error("pointer gap does not match count");
`endif

endmodule

`default_nettype wire

>>> src/http_request_header_tokenizer.sv
`default_nettype none

// Tags each byte of an HTTP request with its role (method, space, path, version, header
// name, header separator, header value, terminator, body, ignored) and flags line ends,
// missing colons, the end of headers, the method code and the request line status. A byte
// is taken in every cycle while the four-entry result queue holds at most two results; the
// step logic between the parser state register and the queue finishes each byte in that
// cycle. A byte yields zero, one or two results (a held CR is released with the byte after
// it), and the output side drains one result per cycle while out_tready is high. Results
// are delivered from the registered result queue, never combinationally from the byte.
module http_request_header_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // in_byte
  input  logic        in_tlast,   // end_of_content
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // out_byte, line_done, header_has_colon, headers_done,
                                  // method_code, parse_status, request_end, zero pad
  output logic [3:0]  out_tuser,  // byte_class
  output logic        out_tlast   // last
);
  import hrt_pkg::*;

  hrt_state_t  state_r, state_nxt;
  hrt_step_t   step;
  hrt_result_t head;
  logic        accept;
  logic        room;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = room;

  hrt_step u_step (
    .st      (state_r),
    .in_byte (in_tdata),
    .eoc     (in_tlast),
    .step    (step)
  );

  assign state_nxt = accept ? step.st_nxt : state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= HRT_STATE_RST;
    end else begin
      state_r <= state_nxt;
    end
  end

  hrt_rq u_rq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push0      (accept && step.push0),
    .push1      (accept && step.push1),
    .din0       (step.res0),
    .din1       (step.res1),
    .room       (room),
    .dout_valid (out_tvalid),
    .pop        (out_tready),
    .dout       (head)
  );

  assign out_tdata = {6'd0, head.request_end, head.parse_status, head.method_code,
                      head.headers_done, head.header_has_colon, head.line_done,
                      head.out_byte};
  assign out_tuser = head.byte_class;
  assign out_tlast = head.last;

`ifndef NO_ASSERTIONS
  a_eoc_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tlast) |=> (state_r == HRT_STATE_RST))
    else $error("state not cleared after end of request");
  a_cr_phase: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.cr_pending |-> (state_r.phase < PH_BODY))
    else $error("carriage return held outside line parsing");
  a_ignore_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == PH_IGNORE) |-> (state_r.status_reg == ST_NO_LINE))
    else $error("ignore phase without line error");
  a_two_imply_one: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && step.push1) |-> step.push0)
    else $error("second result without first");
`endif

endmodule

`default_nettype wire
